// File: rtl/bba_pkg.sv
package bba_pkg;

  localparam int REQ_W    = 32;
  localparam int ADDR_W   = 19;
  localparam int LEVEL_W  = 4;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;
  // request plus header, wide enough for any legal parameter set
  localparam int NEED_W   = 34;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ALLOC_GRANTED   = 2'd0,
    ALLOC_TOO_LARGE = 2'd1,
    ALLOC_NO_REGION = 2'd2
  } alloc_status_t;

  typedef struct packed {
    logic load_need;
    logic load_fit;
    logic load_search;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// File: rtl/bba_if.sv
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::REQ_W-1:0]   request_size;

  modport source (output valid, request_size, input ready);
  modport sink   (input valid, request_size, output ready);
endinterface

interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::ADDR_W-1:0]   payload_address;
  logic [bba_pkg::LEVEL_W-1:0]  granted_level;

  modport source (output valid, status, payload_address, granted_level, input ready);
  modport sink   (input valid, status, payload_address, granted_level, output ready);
endinterface

// File: rtl/buddy_block_allocate.sv
// Buddy allocator, allocation side only. Each word on in_req asks for
// request_size payload bytes; HEADER_BYTES is added and the smallest level
// (block = MIN_BLOCK_BYTES << level, up to TOP_LEVEL) that fits is chosen.
// A free block at that level is granted, else the lowest larger free block
// is split down with each upper buddy left free, else the pool grows by one
// region at the next address. out_rsp returns status (0 granted, 1 too
// large, 2 out of regions), payload_address (block base + header, modulo
// 2^19) and granted_level; address and level are zero on failure. cfg_we /
// cfg_wdata write the region limit (reset 16, clamped to MAX_REGIONS); write
// it only while idle. Timing: an accepted request passes the controller's
// fit, search and commit steps, the result word being registered at the
// commit, and the next request is taken in the cycle after the commit, so
// no new request is taken before the last is committed; a waiting result
// does not block the next acceptance, only the next commit. The free list
// is cleared by reset at once, no clearing pass.
module buddy_block_allocate #(
  parameter int MIN_BLOCK_BYTES = 32,
  parameter int TOP_LEVEL       = 10,
  parameter int HEADER_BYTES    = 32,
  parameter int MAX_REGIONS     = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bba_req_if.sink                     in_req,
  bba_rsp_if.source                   out_rsp,
  input  logic                        cfg_we,
  input  logic [bba_pkg::LIMIT_W-1:0] cfg_wdata
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  // sequencing: idle -> fit -> search -> commit
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // free list, region counter, limit register and output word
  bba_datapath #(
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .TOP_LEVEL       (TOP_LEVEL),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_REGIONS     (MAX_REGIONS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .request_size (in_req.request_size),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_rsp.valid),
    .out_ready    (out_rsp.ready),
    .out_status   (out_rsp.status),
    .out_address  (out_rsp.payload_address),
    .out_level    (out_rsp.granted_level)
  );

endmodule

// File: rtl/bba_ctrl.sv
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FIT    = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_need = 1'b1;
          state_nxt     = S_FIT;
        end
      end
      S_FIT: begin
        cmd.load_fit = 1'b1;
        state_nxt    = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.load_search = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        // wait for a free output slot
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/bba_datapath.sv
module bba_datapath #(
  parameter int MIN_BLOCK_BYTES = 32,
  parameter int TOP_LEVEL       = 10,
  parameter int HEADER_BYTES    = 32,
  parameter int MAX_REGIONS     = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bba_pkg::dp_cmd_t               cmd,
  output bba_pkg::dp_stat_t              stat,
  input  logic [bba_pkg::REQ_W-1:0]      request_size,
  input  logic                           cfg_we,
  input  logic [bba_pkg::LIMIT_W-1:0]    cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bba_pkg::STATUS_W-1:0]   out_status,
  output logic [bba_pkg::ADDR_W-1:0]     out_address,
  output logic [bba_pkg::LEVEL_W-1:0]    out_level
);

  localparam int LEVELS = TOP_LEVEL + 1;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int NW     = bba_pkg::NEED_W;
  localparam int AW     = bba_pkg::ADDR_W;
  localparam logic [NW-1:0] REGION_BYTES = NW'(MIN_BLOCK_BYTES) << TOP_LEVEL;
  localparam logic [AW-1:0] REGION_STEP  = AW'(REGION_BYTES);
  localparam logic [AW-1:0] HDR          = AW'(HEADER_BYTES);

  logic [NW-1:0]                    need_r;
  logic [LVL_W-1:0]                 lvl_r, fit_lvl;
  logic                             too_large_r;
  logic [LVL_W-1:0]                 src_r, src;
  logic                             found_r, found;
  logic                             oor_r, oor;
  logic [AW-1:0]                    base_r;
  logic [LEVELS-1:0]                free_valid_r, free_valid_nxt;
  logic [AW-1:0]                    free_base_r [LEVELS];
  logic [bba_pkg::LIMIT_W-1:0]      regions_r, regions_nxt;
  logic [bba_pkg::LIMIT_W-1:0]      limit_r;
  logic                             grant;
  logic                             out_valid_r;
  logic [bba_pkg::STATUS_W-1:0]     out_status_r;
  logic [AW-1:0]                    out_address_r;
  logic [bba_pkg::LEVEL_W-1:0]      out_level_r;
  bba_pkg::alloc_status_t           res_status;

  // smallest level whose block holds the request
  always_comb begin
    fit_lvl = LVL_W'(TOP_LEVEL);
    for (int k = TOP_LEVEL - 1; k >= 0; k--) begin
      if ((NW'(MIN_BLOCK_BYTES) << k) >= need_r) fit_lvl = LVL_W'(k);
    end
  end

  // lowest free level at or above the fit
  always_comb begin
    src   = LVL_W'(TOP_LEVEL);
    found = 1'b0;
    for (int k = TOP_LEVEL; k >= 0; k--) begin
      if (free_valid_r[k] && (LVL_W'(k) >= lvl_r)) begin
        src   = LVL_W'(k);
        found = 1'b1;
      end
    end
  end

  assign oor   = (regions_r >= limit_r) || (32'(regions_r) >= MAX_REGIONS);
  assign grant = !too_large_r && (found_r || !oor_r);

  always_comb begin
    priority if (too_large_r) res_status = bba_pkg::ALLOC_TOO_LARGE;
    else if (!grant)          res_status = bba_pkg::ALLOC_NO_REGION;
    else                      res_status = bba_pkg::ALLOC_GRANTED;
  end

  always_comb begin
    free_valid_nxt = free_valid_r;
    regions_nxt    = regions_r;
    if (cmd.commit && grant) begin
      if (found_r) free_valid_nxt[src_r] = 1'b0;
      else         regions_nxt = regions_r + 1'b1;
      for (int k = 0; k < LEVELS; k++) begin
        if ((LVL_W'(k) >= lvl_r) && (LVL_W'(k) < src_r)) free_valid_nxt[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_need) need_r <= NW'(request_size) + NW'(HEADER_BYTES);
    if (cmd.load_fit) begin
      lvl_r       <= fit_lvl;
      too_large_r <= need_r > REGION_BYTES;
    end
    if (cmd.load_search) begin
      src_r   <= src;
      found_r <= found;
      oor_r   <= oor;
      base_r  <= found ? free_base_r[src] : AW'(AW'(regions_r) * REGION_STEP);
    end
    // upper buddies on the split path
    for (int k = 0; k < LEVELS; k++) begin
      if (cmd.commit && grant && (LVL_W'(k) >= lvl_r) && (LVL_W'(k) < src_r))
        free_base_r[k] <= base_r + AW'(NW'(MIN_BLOCK_BYTES) << k);
    end
    if (cmd.commit) begin
      out_status_r  <= res_status;
      out_address_r <= grant ? base_r + HDR : '0;
      out_level_r   <= grant ? bba_pkg::LEVEL_W'(lvl_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_valid_r <= '0;
      regions_r    <= '0;
      limit_r      <= bba_pkg::LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      free_valid_r <= free_valid_nxt;
      regions_r    <= regions_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (cmd.commit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign stat.out_full = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_address   = out_address_r;
  assign out_level     = out_level_r;

  a_region_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && grant && !found_r |=> regions_r == $past(regions_r) + 1'b1)
    else $error("region count did not advance on pool growth");

  a_split_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && grant && (lvl_r != src_r) |=> free_valid_r[$past(lvl_r)])
    else $error("buddy at granted level not left free after split");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != bba_pkg::ALLOC_GRANTED)
      |-> (out_address_r == '0) && (out_level_r == '0))
    else $error("failed word carries nonzero address or level");

endmodule
